>>> design/assert_macros.svh
// Assertion macros shared by the verification checkers of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/thumb_enc_pkg.sv
// Shared types, field layouts and codes of the Thumb instruction encoder.
package thumb_enc_pkg;

    // Flag bit positions inside op_flags.
    localparam int FL_LONG   = 0;
    localparam int FL_DS     = 1;
    localparam int FL_IMM    = 2;
    localparam int FL_BRANCH = 3;
    localparam int FL_EXCH   = 4;
    localparam int FL_WORD   = 5;
    localparam int FL_HALF   = 6;
    localparam int FL_POOL   = 7;
    localparam int FL_PCR    = 8;
    localparam int FL_ADDSUB = 9;
    localparam int FL_RSHIFT = 10;
    localparam int FL_REG    = 11;
    localparam int FL_HID    = 12;
    localparam int FL_HIS    = 13;

    localparam int FLAGS_W = 14;
    localparam int FMT_W   = 5;

    // Format numbers, counted from zero.
    localparam logic [FMT_W-1:0] FMT_SHIFT    = 5'd0;
    localparam logic [FMT_W-1:0] FMT_ADDSUB   = 5'd1;
    localparam logic [FMT_W-1:0] FMT_IMM8     = 5'd2;
    localparam logic [FMT_W-1:0] FMT_ALU      = 5'd3;
    localparam logic [FMT_W-1:0] FMT_HIREG    = 5'd4;
    localparam logic [FMT_W-1:0] FMT_PCLOAD   = 5'd5;
    localparam logic [FMT_W-1:0] FMT_REGOFF   = 5'd6;
    localparam logic [FMT_W-1:0] FMT_SIGNEXT  = 5'd7;
    localparam logic [FMT_W-1:0] FMT_IMMOFF   = 5'd8;
    localparam logic [FMT_W-1:0] FMT_HALFOFF  = 5'd9;
    localparam logic [FMT_W-1:0] FMT_SPREL    = 5'd10;
    localparam logic [FMT_W-1:0] FMT_LOADADDR = 5'd11;
    localparam logic [FMT_W-1:0] FMT_SPADJ    = 5'd12;
    localparam logic [FMT_W-1:0] FMT_PUSHPOP  = 5'd13;
    localparam logic [FMT_W-1:0] FMT_MULTI    = 5'd14;
    localparam logic [FMT_W-1:0] FMT_COND     = 5'd15;
    localparam logic [FMT_W-1:0] FMT_SWI      = 5'd16;
    localparam logic [FMT_W-1:0] FMT_UNCOND   = 5'd17;
    localparam logic [FMT_W-1:0] FMT_LONGBL   = 5'd18;

    // Opcode bits toggled to turn add into subtract and back.
    localparam logic [15:0] FLIP_ADDSUB = 16'h0200;
    localparam logic [15:0] FLIP_IMM8   = 16'h0800;
    localparam logic [15:0] FLIP_SPADJ  = 16'h0080;

    // Second halfword prefixes of the long branch with link.
    localparam logic [15:0] BL_LOW_EXCH = 16'hE800;
    localparam logic [15:0] BL_LOW      = 16'hF800;

    localparam logic [31:0] PC_ALIGN_MASK = 32'hFFFF_FFFD;
    localparam logic [31:0] PC_MAX_OFFSET = 32'd1020;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_BR_WORD    = 4'd1,
        ERR_BR_HALF    = 4'd2,
        ERR_BR_RANGE   = 4'd3,
        ERR_MUL4       = 4'd4,
        ERR_MUL2       = 4'd5,
        ERR_PCR_ALIGN  = 4'd6,
        ERR_PCR_RANGE  = 4'd7,
        ERR_SHIFT      = 4'd8,
        ERR_IMM_RANGE  = 4'd9,
        ERR_POOL_RANGE = 4'd10
    } err_code_t;

    // One input word; the last field sits in the lowest bits.
    typedef struct packed {
        logic [31:0] pool_address;
        logic [4:0]  imm_bit_length;
        logic [31:0] instr_address;
        logic [31:0] immediate;
        logic [15:0] reg_list;
        logic [2:0]  offset_reg;
        logic [2:0]  second_reg;
        logic [3:0]  source_reg;
        logic [3:0]  dest_reg;
        logic [15:0] base_opcode;
    } item_t;

    // Kind of instruction, carried beside the data.
    typedef struct packed {
        logic [FLAGS_W-1:0] op_flags;
        logic [FMT_W-1:0]   format_type;
    } kind_t;

    // One result word; the last field sits in the lowest bits.
    typedef struct packed {
        logic      misaligned_warning;
        err_code_t error_code;
        logic [1:0]  halfword_count;
        logic [15:0] second_halfword;
        logic [15:0] first_halfword;
    } result_t;

    localparam int ITEM_W    = $bits(item_t);
    localparam int KIND_W    = $bits(kind_t);
    localparam int RESULT_W  = $bits(result_t);
    localparam int IN_DATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int IN_USER_W  = ((KIND_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Converted immediate handed from the check stage to the field merge.
    typedef struct packed {
        logic [31:0] value;
        logic [15:0] opcode;
        err_code_t   err;
    } imm_res_t;

endpackage

>>> design/thumb_enc_imm.sv
// Immediate checks and conversion: alignment, range, scaling and add/sub flip.
module thumb_enc_imm (
    input  thumb_enc_pkg::item_t    item,
    input  thumb_enc_pkg::kind_t    kind,
    output thumb_enc_pkg::imm_res_t res
);
    import thumb_enc_pkg::*;

    logic [FLAGS_W-1:0] fl;
    logic [FMT_W-1:0]   fmt;
    logic [31:0]        fmask;
    logic [31:0]        imm0;
    logic [31:0]        num;
    logic signed [32:0] sn;
    logic signed [32:0] bound;
    logic               br_range_bad;
    logic [31:0]        br_half;
    logic [31:0]        br_val;
    logic [31:0]        pc_target;
    logic [31:0]        pc_diff;
    logic               pc_bad;
    logic [31:0]        pc_val;
    logic [31:0]        imm1;
    err_code_t          err1;
    logic [32:0]        neg_mag;
    logic [15:0]        flip;
    logic               do_flip;
    logic [31:0]        imm2;
    logic [15:0]        opc2;
    logic [31:0]        shift_max;

    assign fl    = kind.op_flags;
    assign fmt   = kind.format_type;
    assign fmask = (32'd1 << item.imm_bit_length) - 32'd1;
    assign imm0  = fl[FL_IMM] ? item.immediate : 32'd0;

    // Branch offset relative to the prefetched PC, halved.
    assign num          = imm0 - item.instr_address - 32'd4;
    assign sn           = $signed({num[31], num});
    assign bound        = $signed(33'd1 << item.imm_bit_length);
    assign br_range_bad = (sn >= bound) || (sn < -bound);
    assign br_half      = {num[31], num[31:1]};
    assign br_val       = br_half + (fl[FL_EXCH] ? {31'd0, br_half[0]} : 32'd0);

    // Word offset from the PC with bit 1 cleared, shared by pool and PC-relative forms.
    assign pc_target = fl[FL_POOL] ? item.pool_address : imm0;
    assign pc_diff   = pc_target - ((item.instr_address + 32'd4) & PC_ALIGN_MASK);
    assign pc_bad    = pc_diff[31] || (pc_diff > PC_MAX_OFFSET);
    assign pc_val    = {24'd0, pc_diff[9:2]};

    // First conversion step, chosen by the operand kind.
    always_comb
    begin
        imm1 = imm0;
        err1 = ERR_NONE;
        if (fl[FL_IMM])
        begin
            priority if (fl[FL_BRANCH])
            begin
                if (fl[FL_EXCH] && (imm0[1:0] != 2'd0))
                    err1 = ERR_BR_WORD;
                else if (!fl[FL_EXCH] && imm0[0])
                    err1 = ERR_BR_HALF;
                else if (br_range_bad)
                    err1 = ERR_BR_RANGE;
                else
                    imm1 = br_val;
            end
            else if (fl[FL_WORD])
            begin
                if (imm0[1:0] != 2'd0)
                    err1 = ERR_MUL4;
                else
                    imm1 = {{2{imm0[31]}}, imm0[31:2]};
            end
            else if (fl[FL_HALF])
            begin
                if (imm0[0])
                    err1 = ERR_MUL2;
                else
                    imm1 = {imm0[31], imm0[31:1]};
            end
            else if (fl[FL_POOL])
            begin
                if (pc_bad)
                    err1 = ERR_POOL_RANGE;
                else
                    imm1 = pc_val;
            end
            else if (fl[FL_PCR])
            begin
                if (imm0[1:0] != 2'd0)
                    err1 = ERR_PCR_ALIGN;
                else if (pc_bad)
                    err1 = ERR_PCR_RANGE;
                else
                    imm1 = pc_val;
            end
            else
            begin
                imm1 = imm0;
            end
        end
    end

    // A small negative add or subtract immediate becomes the opposite operation.
    assign neg_mag = 33'd0 - {imm1[31], imm1};

    always_comb
    begin
        unique case (fmt)
            FMT_ADDSUB: flip = FLIP_ADDSUB;
            FMT_IMM8:   flip = FLIP_IMM8;
            FMT_SPADJ:  flip = FLIP_SPADJ;
            default:    flip = 16'd0;
        endcase
    end

    assign do_flip = fl[FL_IMM] && (err1 == ERR_NONE) && fl[FL_ADDSUB] && imm1[31]
                     && (neg_mag <= {1'b0, fmask}) && (flip != 16'd0);
    assign imm2    = do_flip ? (32'd0 - imm1) : imm1;
    assign opc2    = do_flip ? (item.base_opcode ^ flip) : item.base_opcode;

    assign shift_max = fl[FL_RSHIFT] ? 32'd32 : 32'd31;

    // Final range checks and masking of branch fields.
    always_comb
    begin
        res.value  = imm2;
        res.opcode = opc2;
        res.err    = err1;
        if (fl[FL_IMM] && (err1 == ERR_NONE))
        begin
            priority if (fmt == FMT_SHIFT)
            begin
                if (imm2[31] || (imm2 > shift_max))
                    res.err = ERR_SHIFT;
            end
            else if (fl[FL_BRANCH])
            begin
                res.value = imm2 & fmask;
            end
            else if (!(fl[FL_POOL] || fl[FL_PCR]))
            begin
                if (imm2[31] || (imm2 > fmask))
                    res.err = ERR_IMM_RANGE;
            end
            else
            begin
                res.value = imm2;
            end
        end
    end

endmodule

>>> design/thumb_enc_pack.sv
// Field merge: places registers and the converted immediate into the opcode.
module thumb_enc_pack (
    input  thumb_enc_pkg::item_t    item,
    input  thumb_enc_pkg::kind_t    kind,
    input  thumb_enc_pkg::imm_res_t imm,
    output thumb_enc_pkg::result_t  result
);
    import thumb_enc_pkg::*;

    logic [FLAGS_W-1:0] fl;
    logic [3:0]         rd;
    logic [3:0]         rs;
    logic [15:0]        rd_lo;
    logic [15:0]        rs_mid;
    logic [15:0]        rd_hi;
    logic [15:0]        imm_at6;
    logic [15:0]        enc;
    logic [15:0]        second;

    assign fl      = kind.op_flags;
    assign rd      = item.dest_reg;
    assign rs      = fl[FL_DS] ? item.dest_reg : item.source_reg;
    assign rd_lo   = {12'd0, rd};
    assign rs_mid  = {9'd0, rs, 3'd0};
    assign rd_hi   = {4'd0, rd, 8'd0};
    assign imm_at6 = {imm.value[9:0], 6'd0};

    // Merge operand fields by format.
    always_comb
    begin
        enc    = imm.opcode;
        second = 16'd0;
        unique case (kind.format_type)
            FMT_SHIFT:
            begin
                if (fl[FL_RSHIFT] && (imm.value == 32'd0))
                    enc = 16'd0;
                enc = enc | {5'd0, imm.value[4:0], 6'd0} | rs_mid | rd_lo;
            end
            FMT_ADDSUB:
            begin
                if (fl[FL_IMM])
                    enc = enc | imm_at6;
                else if (fl[FL_REG])
                    enc = enc | {7'd0, item.second_reg, 6'd0};
                enc = enc | rs_mid | rd_lo;
            end
            FMT_IMM8, FMT_PCLOAD, FMT_LOADADDR:
                enc = enc | rd_hi | imm.value[15:0];
            FMT_ALU:
                enc = enc | rs_mid | rd_lo;
            FMT_HIREG:
            begin
                if (fl[FL_HID])
                    enc = enc | {8'd0, rd[3], 4'd0, rd[2:0]};
                if (fl[FL_HIS])
                    enc = enc | {9'd0, rs[3], rs[2:0], 3'd0};
            end
            FMT_REGOFF, FMT_SIGNEXT:
                enc = enc | {7'd0, item.offset_reg, 6'd0} | rs_mid | rd_lo;
            FMT_IMMOFF, FMT_HALFOFF:
            begin
                if (fl[FL_IMM])
                    enc = enc | imm_at6;
                enc = enc | rs_mid | rd_lo;
            end
            FMT_SPREL:
            begin
                enc = enc | rd_hi;
                if (fl[FL_IMM])
                    enc = enc | imm.value[15:0];
            end
            FMT_SPADJ, FMT_COND, FMT_SWI, FMT_UNCOND:
                enc = enc | imm.value[15:0];
            FMT_PUSHPOP:
                enc = enc | {7'd0, item.reg_list[15] | item.reg_list[14], 8'd0}
                          | {8'd0, item.reg_list[7:0]};
            FMT_MULTI:
                enc = enc | rd_hi | {8'd0, item.reg_list[7:0]};
            FMT_LONGBL:
            begin
                if (fl[FL_LONG])
                begin
                    enc    = enc | {5'd0, imm.value[21:11]};
                    second = (fl[FL_EXCH] ? BL_LOW_EXCH : BL_LOW)
                             | {5'd0, imm.value[10:0]};
                end
                else if (fl[FL_IMM])
                begin
                    enc = enc | {5'd0, imm.value[10:0]};
                end
            end
            default:
                enc = imm.opcode;
        endcase
    end

    // Both halfwords read zero when a check failed.
    assign result.first_halfword     = (imm.err == ERR_NONE) ? enc : 16'd0;
    assign result.second_halfword    = (imm.err == ERR_NONE) ? second : 16'd0;
    assign result.halfword_count     = fl[FL_LONG] ? 2'd2 : 2'd1;
    assign result.error_code         = imm.err;
    assign result.misaligned_warning = item.instr_address[0];

endmodule

>>> design/thumb_instruction_encoder.sv
// Top level of the Thumb instruction encoder: stream ports and the two register stages.
//
// One parsed instruction enters on the s_axis channel as a word: format number and
// flags travel in s_axis_tuser, the registers, immediate and addresses in s_axis_tdata.
// Each word gives exactly one result word on the m_axis channel: the encoded
// halfwords, the halfword count, an error code and a misaligned-address warning.
// A word is accepted at a clock edge where tvalid and tready are both high.
//
// The word is captured in the input register at the accepting edge, checked and
// encoded by one pass of combinational logic, and captured in the result register
// once that register is empty or being drained; m_axis_tvalid follows the result
// register. Throughput is one word per cycle while m_axis_tready stays high.
//
// When the receiver holds m_axis_tready low, the result stays unchanged on the port.
// The input register still takes one more word while the result register is full;
// after that s_axis_tready falls until the result is taken.
// Reset empties both stages, so s_axis_tready is high once it is released.
module thumb_instruction_encoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // From bit 0: base_opcode, dest_reg, source_reg, second_reg, offset_reg, reg_list,
    // immediate, instr_address, imm_bit_length, pool_address, zero padding.
    input  logic [thumb_enc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // From bit 0: format_type, op_flags, zero padding.
    input  logic [thumb_enc_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // From bit 0: first_halfword, second_halfword, halfword_count, error_code,
    // misaligned_warning, zero padding.
    output logic [thumb_enc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import thumb_enc_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    item_t    item_reg;
    kind_t    kind_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  result_reg;
    logic     out_ready;
    imm_res_t imm_res;
    result_t  result_comb;

    // A stage moves on when the one after it is empty or being drained.
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_comb
    begin
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_t'(s_axis_tdata[ITEM_W-1:0]);
            kind_reg <= kind_t'(s_axis_tuser[KIND_W-1:0]);
        end
    end

    // Immediate checks and conversion.
    thumb_enc_imm u_imm (
        .item (item_reg),
        .kind (kind_reg),
        .res  (imm_res)
    );

    // Operand field merge.
    thumb_enc_pack u_pack (
        .item   (item_reg),
        .kind   (kind_reg),
        .imm    (imm_res),
        .result (result_comb)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg && out_ready)
            result_reg <= result_comb;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, result_reg};

endmodule

>>> design/thumb_enc_checker.sv
// Port-level checker of the Thumb instruction encoder and its bind statement.
`include "assert_macros.svh"

module thumb_enc_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [thumb_enc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import thumb_enc_pkg::*;

    result_t res;

    assign res = result_t'(m_axis_tdata[RESULT_W-1:0]);

    // A stalled result word holds.
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // A failed check never leaves an encoding behind.
    `ASSERT_IMPL(a_err_zero, clk, rst_n, m_axis_tvalid && (res.error_code != ERR_NONE), (res.first_halfword == 16'd0) && (res.second_halfword == 16'd0))

    // A second halfword only appears in a two-halfword result.
    `ASSERT_IMPL(a_second_count, clk, rst_n, m_axis_tvalid && (res.second_halfword != 16'd0), res.halfword_count == 2'd2)

    // Count and error code stay within their defined codes.
    `ASSERT_IMPL(a_codes, clk, rst_n, m_axis_tvalid, ((res.halfword_count == 2'd1) || (res.halfword_count == 2'd2)) && (res.error_code <= ERR_POOL_RANGE))

endmodule

bind thumb_instruction_encoder thumb_enc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
